// ===== hdl/ffa_pkg.sv =====
// Package with types, constants and state codes of the first-fit allocator.
package ffa_pkg;

   localparam int POOL_CAPACITY_DEF     = 1024;
   localparam int MAX_FREE_SEGMENTS_DEF = 32;
   localparam int HEADER_BYTES_DEF      = 8;
   localparam int MIN_BLOCK_BYTES_DEF   = 24;

   localparam int LEN_W  = 11;
   localparam int ADDR_W = 10;
   localparam int CNT_W  = 6;
   localparam int CSR_ADDR_W = 2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NO_FIT  = 2'd1;
   localparam logic [1:0] STATUS_BAD     = 2'd2;
   localparam logic [1:0] STATUS_FULL    = 2'd3;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [CSR_ADDR_W-1:0] REG_POOL_LENGTH = '0;

   typedef struct packed {
      logic              operation;
      logic [ADDR_W-1:0] request_size;
      logic [ADDR_W-1:0] block_address;
   } req_word_type;

   typedef struct packed {
      logic [ADDR_W-1:0] payload_address;
      logic [1:0]        status;
   } rsp_word_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_SCAN,
      ST_SCAN_WAIT,
      ST_LEN_READ,
      ST_LEN_WAIT,
      ST_LEN_CHECK,
      ST_WALK,
      ST_DECIDE,
      ST_SHIFT_DN,
      ST_SHIFT_UP,
      ST_STORE,
      ST_RESPOND
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;
      logic init_step;
      logic scan_read;
      logic scan_eval;
      logic len_read;
      logic len_latch;
      logic apply;
      logic shift_dn;
      logic shift_up;
      logic store_write;
      logic set_status;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_free;
      logic early_bad;
      logic init_done;
      logic scan_done;
      logic len_bad;
      logic decide_fail;
      logic need_dn;
      logic need_up;
      logic need_store;
   } stat_type;

endpackage

// ===== hdl/ffa_ram.sv =====
// Generic single-port RAM with registered read.
module ffa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== hdl/ffa_datapath.sv =====
// Datapath of the allocator: free table, block length store and arithmetic.
module ffa_datapath
   import ffa_pkg::*;
#(
   parameter int POOL_CAPACITY     = POOL_CAPACITY_DEF,
   parameter int MAX_FREE_SEGMENTS = MAX_FREE_SEGMENTS_DEF,
   parameter int HEADER_BYTES      = HEADER_BYTES_DEF,
   parameter int MIN_BLOCK_BYTES   = MIN_BLOCK_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ffa_pkg::cmd_type      cmd,
   output ffa_pkg::stat_type     stat,
   input  ffa_pkg::req_word_type req_word,
   input  logic                  cfg_write,
   input  logic [ffa_pkg::LEN_W-1:0] cfg_value,
   output logic [ffa_pkg::LEN_W-1:0] pool_length,
   output ffa_pkg::rsp_word_type rsp_word
);
   localparam int PW = $clog2(POOL_CAPACITY) + 2;
   localparam int SI = $clog2(MAX_FREE_SEGMENTS);
   localparam int CW = $clog2(MAX_FREE_SEGMENTS + 1);
   localparam int AW = $clog2(POOL_CAPACITY);

   logic [PW-1:0] seg_start_ff [MAX_FREE_SEGMENTS];
   logic [PW-1:0] seg_start_in [MAX_FREE_SEGMENTS];
   logic [PW-1:0] seg_len_ff   [MAX_FREE_SEGMENTS];
   logic [PW-1:0] seg_len_in   [MAX_FREE_SEGMENTS];
   logic [CW-1:0] count_ff, count_in;
   logic [PW-1:0] pool_ff, pool_in;
   logic          op_ff, op_in;
   logic [PW-1:0] need_ff, need_in;
   logic [PW-1:0] bstart_ff, bstart_in;
   logic [PW-1:0] blen_ff, blen_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic          found_ff, found_in;
   logic          overlap_ff, overlap_in;
   logic [CW-1:0] sh_ff, sh_in;
   logic [PW-1:0] st_val_ff, st_val_in;
   logic [PW-1:0] st_addr_ff, st_addr_in;
   logic [AW:0]   init_ff, init_in;
   logic [ADDR_W-1:0] out_addr_ff, out_addr_in;
   logic [1:0]    out_stat_ff, out_stat_in;
   logic          need_dn_ff, need_dn_in, need_up_ff, need_up_in;

   logic          ram_we;
   logic [AW-1:0] ram_addr;
   logic [LEN_W-1:0] ram_wdata, ram_rdata;

   ffa_ram #(.WIDTH(LEN_W), .DEPTH(POOL_CAPACITY)) u_len_ram (
      .clock(clock), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
   );

   logic [PW-1:0] cs, cl, cend, bend, ps, pl, nx;
   logic [SI-1:0] ci;
   logic [PW-1:0] clamp;
   logic [PW-1:0] addr_w, sz_w;

   always_comb begin
      ci   = idx_ff[SI-1:0];
      cs   = seg_start_ff[ci];
      cl   = seg_len_ff[ci];
      cend = cs + cl;
      bend = bstart_ff + blen_ff;
      ps   = seg_start_ff[SI'(pos_ff - CW'(1))];
      pl   = seg_len_ff[SI'(pos_ff - CW'(1))];
      nx   = seg_start_ff[pos_ff[SI-1:0]];
      addr_w = PW'(req_word.block_address);
      sz_w   = PW'(req_word.request_size);
      clamp  = PW'(cfg_value);
      if (clamp < PW'(MIN_BLOCK_BYTES + 1)) clamp = PW'(MIN_BLOCK_BYTES + 1);
      if (clamp > PW'(POOL_CAPACITY)) clamp = PW'(POOL_CAPACITY);
   end

   logic mp, mn;
   always_comb begin
      mp = (pos_ff != '0) && (ps + pl == bstart_ff);
      mn = (pos_ff < count_ff) && (bend == nx);
   end

   always_comb begin
      seg_start_in = seg_start_ff;
      seg_len_in   = seg_len_ff;
      count_in  = count_ff;
      pool_in   = pool_ff;
      op_in     = op_ff;
      need_in   = need_ff;
      bstart_in = bstart_ff;
      blen_in   = blen_ff;
      idx_in    = idx_ff;
      pos_in    = pos_ff;
      found_in  = found_ff;
      overlap_in = overlap_ff;
      sh_in     = sh_ff;
      st_val_in = st_val_ff;
      st_addr_in = st_addr_ff;
      init_in   = init_ff;
      out_addr_in = out_addr_ff;
      out_stat_in = out_stat_ff;
      need_dn_in = need_dn_ff;
      need_up_in = need_up_ff;
      ram_we    = 1'b0;
      ram_addr  = bstart_ff[AW-1:0];
      ram_wdata = '0;

      if (cfg_write) begin
         pool_in = clamp;
         seg_start_in[0] = '0;
         seg_len_in[0] = clamp;
         count_in = CW'(1);
      end
      if (cmd.init_step) begin
         ram_we = 1'b1;
         ram_addr = init_ff[AW-1:0];
         init_in = init_ff + 1'b1;
      end
      if (cfg_write) begin
         init_in = '0;
      end
      if (cmd.load_req) begin
         op_in = req_word.operation;
         need_in = ((sz_w > PW'(MIN_BLOCK_BYTES)) ? sz_w : PW'(MIN_BLOCK_BYTES))
                   + PW'(HEADER_BYTES);
         bstart_in = addr_w - PW'(HEADER_BYTES);
         idx_in = '0;
         pos_in = count_ff;
         found_in = 1'b0;
         overlap_in = 1'b0;
         out_addr_in = '0;
         out_stat_in = STATUS_OK;
      end
      if (cmd.len_read) begin
         ram_addr = bstart_ff[AW-1:0];
      end
      if (cmd.len_latch) begin
         blen_in = PW'(ram_rdata);
      end
      if (cmd.scan_eval && idx_ff < count_ff) begin
         if (op_ff == OP_ALLOC) begin
            if (!found_ff && cl > need_ff) begin
               found_in = 1'b1;
               pos_in = idx_ff;
            end
         end else begin
            if (cs < bend && bstart_ff < cend) overlap_in = 1'b1;
            if (!found_ff && cs > bstart_ff) begin
               found_in = 1'b1;
               pos_in = idx_ff;
            end
         end
         idx_in = idx_ff + 1'b1;
      end
      if (cmd.apply) begin
         need_dn_in = 1'b0;
         need_up_in = 1'b0;
         if (op_ff == OP_ALLOC) begin
            st_addr_in = seg_start_ff[pos_ff[SI-1:0]];
            out_addr_in = ADDR_W'(seg_start_ff[pos_ff[SI-1:0]] + PW'(HEADER_BYTES));
            if (seg_len_ff[pos_ff[SI-1:0]] < need_ff + PW'(MIN_BLOCK_BYTES)) begin
               st_val_in = seg_len_ff[pos_ff[SI-1:0]];
               need_dn_in = 1'b1;
               sh_in = pos_ff;
            end else begin
               st_val_in = need_ff;
               seg_start_in[pos_ff[SI-1:0]] = seg_start_ff[pos_ff[SI-1:0]] + need_ff;
               seg_len_in[pos_ff[SI-1:0]] = seg_len_ff[pos_ff[SI-1:0]] - need_ff;
            end
         end else begin
            st_addr_in = bstart_ff;
            st_val_in = '0;
            if (mp && mn) begin
               seg_len_in[SI'(pos_ff - CW'(1))] = pl + blen_ff + seg_len_ff[pos_ff[SI-1:0]];
               need_dn_in = 1'b1;
               sh_in = pos_ff;
            end else if (mp) begin
               seg_len_in[SI'(pos_ff - CW'(1))] = pl + blen_ff;
            end else if (mn) begin
               seg_start_in[pos_ff[SI-1:0]] = bstart_ff;
               seg_len_in[pos_ff[SI-1:0]] = seg_len_ff[pos_ff[SI-1:0]] + blen_ff;
            end else if (count_ff < CW'(MAX_FREE_SEGMENTS)) begin
               need_up_in = 1'b1;
               sh_in = count_ff;
            end else begin
               out_stat_in = STATUS_FULL;
            end
         end
      end
      if (cmd.shift_dn) begin
         if (sh_ff + CW'(1) < count_ff) begin
            seg_start_in[sh_ff[SI-1:0]] = seg_start_ff[SI'(sh_ff + CW'(1))];
            seg_len_in[sh_ff[SI-1:0]] = seg_len_ff[SI'(sh_ff + CW'(1))];
            sh_in = sh_ff + CW'(1);
         end else begin
            count_in = count_ff - CW'(1);
            need_dn_in = 1'b0;
         end
      end
      if (cmd.shift_up) begin
         if (sh_ff > pos_ff) begin
            seg_start_in[sh_ff[SI-1:0]] = seg_start_ff[SI'(sh_ff - CW'(1))];
            seg_len_in[sh_ff[SI-1:0]] = seg_len_ff[SI'(sh_ff - CW'(1))];
            sh_in = sh_ff - CW'(1);
         end else begin
            seg_start_in[pos_ff[SI-1:0]] = bstart_ff;
            seg_len_in[pos_ff[SI-1:0]] = blen_ff;
            count_in = count_ff + CW'(1);
            need_up_in = 1'b0;
         end
      end
      if (cmd.store_write) begin
         ram_we = 1'b1;
         ram_addr = st_addr_ff[AW-1:0];
         ram_wdata = LEN_W'(st_val_ff);
      end
      if (cmd.set_status) begin
         out_addr_in = '0;
         out_stat_in = (op_ff == OP_ALLOC) ? STATUS_NO_FIT : STATUS_BAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_start_ff[0] <= '0;
         seg_len_ff[0] <= PW'(POOL_CAPACITY);
         count_ff <= CW'(1);
         pool_ff <= PW'(POOL_CAPACITY);
         init_ff <= '0;
         need_dn_ff <= 1'b0;
         need_up_ff <= 1'b0;
      end else begin
         seg_start_ff <= seg_start_in;
         seg_len_ff <= seg_len_in;
         count_ff <= count_in;
         pool_ff <= pool_in;
         init_ff <= init_in;
         need_dn_ff <= need_dn_in;
         need_up_ff <= need_up_in;
      end
      op_ff <= op_in;
      need_ff <= need_in;
      bstart_ff <= bstart_in;
      blen_ff <= blen_in;
      idx_ff <= idx_in;
      pos_ff <= pos_in;
      found_ff <= found_in;
      overlap_ff <= overlap_in;
      sh_ff <= sh_in;
      st_val_ff <= st_val_in;
      st_addr_ff <= st_addr_in;
      out_addr_ff <= out_addr_in;
      out_stat_ff <= out_stat_in;
   end

   always_comb begin
      stat.is_free = op_ff;
      stat.early_bad = (bstart_ff >= pool_ff) || (bstart_ff >= PW'(POOL_CAPACITY))
                       || (bstart_ff > PW'(POOL_CAPACITY));
      stat.init_done = (init_ff == (AW+1)'(POOL_CAPACITY));
      stat.scan_done = (idx_ff >= count_ff);
      stat.len_bad = (blen_ff == '0) || (bend > pool_ff);
      stat.decide_fail = (op_ff == OP_ALLOC) ? !found_ff : overlap_ff;
      stat.need_dn = need_dn_ff;
      stat.need_up = need_up_ff;
      stat.need_store = (out_stat_ff == STATUS_OK);
   end

   assign pool_length = LEN_W'(pool_ff);
   assign rsp_word.payload_address = out_addr_ff;
   assign rsp_word.status = out_stat_ff;
endmodule

// ===== hdl/ffa_control.sv =====
// Controller state machine that sequences the allocator datapath.
module ffa_control
   import ffa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic              req_is_free,
   input  logic              req_addr_low,
   input  logic              cfg_write,
   output ffa_pkg::cmd_type  cmd,
   input  ffa_pkg::stat_type stat
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            cmd.init_step = 1'b1;
            if (stat.init_done && !cfg_write) begin
               cmd.init_step = 1'b0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (cfg_write) begin
               state_in = ST_INIT;
            end else begin
               req_ready = 1'b1;
               if (req_valid) begin
                  cmd.load_req = 1'b1;
                  if (req_is_free && req_addr_low) begin
                     state_in = ST_SCAN_WAIT;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end
            end
         end
         ST_SCAN_WAIT: begin
            cmd.set_status = 1'b1;
            state_in = ST_RESPOND;
         end
         ST_SCAN: begin
            if (stat.is_free) begin
               if (stat.early_bad) begin
                  cmd.set_status = 1'b1;
                  state_in = ST_RESPOND;
               end else begin
                  cmd.len_read = 1'b1;
                  state_in = ST_LEN_READ;
               end
            end else begin
               state_in = ST_WALK;
            end
         end
         ST_LEN_READ: begin
            cmd.len_read = 1'b1;
            state_in = ST_LEN_WAIT;
         end
         ST_LEN_WAIT: begin
            cmd.len_latch = 1'b1;
            state_in = ST_LEN_CHECK;
         end
         ST_LEN_CHECK: begin
            if (stat.len_bad) begin
               cmd.set_status = 1'b1;
               state_in = ST_RESPOND;
            end else begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            cmd.scan_eval = 1'b1;
            if (stat.scan_done) begin
               cmd.scan_eval = 1'b0;
               state_in = ST_DECIDE;
            end
         end
         ST_STORE: begin
            if (stat.need_store) begin
               cmd.store_write = 1'b1;
               state_in = ST_RESPOND;
            end else begin
               state_in = ST_RESPOND;
            end
         end
         ST_DECIDE: begin
            if (stat.decide_fail) begin
               cmd.set_status = 1'b1;
               state_in = ST_RESPOND;
            end else begin
               cmd.apply = 1'b1;
               state_in = ST_SHIFT_DN;
            end
         end
         ST_SHIFT_DN: begin
            if (stat.need_dn) begin
               cmd.shift_dn = 1'b1;
            end else if (stat.need_up) begin
               state_in = ST_SHIFT_UP;
            end else begin
               state_in = ST_STORE;
            end
         end
         ST_SHIFT_UP: begin
            if (stat.need_up) begin
               cmd.shift_up = 1'b1;
            end else begin
               state_in = ST_STORE;
            end
         end
         ST_RESPOND: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end
endmodule

// ===== hdl/first_fit_free_list_allocator.sv =====
// Top level of the first-fit free-list allocator with coalescing.
// One word is handled at a time. An allocate scans the free table one segment a cycle; a free
// first reads the length store (a registered memory) and then scans the same way. Removing or
// inserting a table entry shifts the entries behind it one place at a time. After reset and
// after every pool_length write a clearing pass over all POOL_CAPACITY entries sweeps the
// length store before the next word is taken. The user must write pool_length only while no
// word is in flight; the block itself does not enforce this.
module first_fit_free_list_allocator
   import ffa_pkg::*;
#(
   parameter int POOL_CAPACITY     = ffa_pkg::POOL_CAPACITY_DEF,
   parameter int MAX_FREE_SEGMENTS = ffa_pkg::MAX_FREE_SEGMENTS_DEF,
   parameter int HEADER_BYTES      = ffa_pkg::HEADER_BYTES_DEF,
   parameter int MIN_BLOCK_BYTES   = ffa_pkg::MIN_BLOCK_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ffa_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ffa_pkg::rsp_word_type rsp_word,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [ffa_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);
   cmd_type  cmd;
   stat_type stat;
   logic     cfg_write;
   logic [LEN_W-1:0] pool_length;

   assign csr_pready = 1'b1;
   assign cfg_write = csr_psel && csr_penable && csr_pwrite
                      && (csr_paddr == REG_POOL_LENGTH);
   assign csr_prdata = (csr_paddr == REG_POOL_LENGTH) ? 32'(pool_length) : '0;

   ffa_datapath #(
      .POOL_CAPACITY(POOL_CAPACITY), .MAX_FREE_SEGMENTS(MAX_FREE_SEGMENTS),
      .HEADER_BYTES(HEADER_BYTES), .MIN_BLOCK_BYTES(MIN_BLOCK_BYTES)
   ) u_datapath (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat), .req_word(req_word),
      .cfg_write(cfg_write), .cfg_value(csr_pwdata[LEN_W-1:0]),
      .pool_length(pool_length), .rsp_word(rsp_word)
   );

   ffa_control u_control (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .req_is_free(req_word.operation == OP_FREE),
      .req_addr_low(req_word.block_address < ADDR_W'(HEADER_BYTES)),
      .cfg_write(cfg_write),
      .cmd(cmd), .stat(stat)
   );

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready and valid at once");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("second word taken");
endmodule
